// ===== rtl/eyvm_pkg.sv =====
`default_nettype none
package eyvm_pkg;

    localparam int TrigIterDefault = 16;
    localparam int AtanCount = 24;
    localparam logic signed [33:0] Q30HalfPi = 34'sd1686629713;
    localparam logic signed [33:0] Q30Pi = 34'sd3373259426;
    localparam logic signed [33:0] Q30One = 34'sd1073741824;
    localparam logic signed [33:0] GainInv = 34'sd652032874;
    localparam logic signed [31:0] OneQ16 = 32'sh0001_0000;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] roll;
    } t_item;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] r;
        unique case (i)
            5'd0: r = 34'sh03243F6A8;
            5'd1: r = 34'sh01DAC6705;
            5'd2: r = 34'sh00FADBAFC;
            5'd3: r = 34'sh007F56EA6;
            5'd4: r = 34'sh003FEAB76;
            5'd5: r = 34'sh001FFD55B;
            5'd6: r = 34'sh000FFFAAA;
            5'd7: r = 34'sh0007FFF55;
            5'd8: r = 34'sh0003FFFEA;
            5'd9: r = 34'sh0001FFFFD;
            5'd10: r = 34'sh0000FFFFF;
            5'd11: r = 34'sh00007FFFF;
            5'd12: r = 34'sh00003FFFF;
            5'd13: r = 34'sh00001FFFF;
            5'd14: r = 34'sh00000FFFF;
            5'd15: r = 34'sh000007FFF;
            5'd16: r = 34'sh000003FFF;
            5'd17: r = 34'sh000001FFF;
            5'd18: r = 34'sh000000FFF;
            5'd19: r = 34'sh0000007FF;
            5'd20: r = 34'sh0000003FF;
            5'd21: r = 34'sh0000001FF;
            5'd22: r = 34'sh0000000FF;
            5'd23: r = 34'sh00000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/euler_yxz_view_matrix.sv =====
`default_nettype none
// Each item is queued, then its sines and cosines, products and translation are computed in turn.
// Sixteen entries follow on consecutive cycles, one per strobe.
// Items are computed one at a time, since all three angles share a single CORDIC.
// A two-item queue lets start be taken while an earlier item is still computed.
// Reset is synchronous and active low and empties the queue; the receiver cannot stall.
module euler_yxz_view_matrix #(
    parameter int TRIG_ITERATIONS = eyvm_pkg::TrigIterDefault
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic signed [31:0]  i_pos_x,
    input  wire logic signed [31:0]  i_pos_y,
    input  wire logic signed [31:0]  i_pos_z,
    input  wire logic signed [15:0]  i_pitch_angle,
    input  wire logic signed [15:0]  i_yaw_angle,
    input  wire logic signed [15:0]  i_roll_angle,
    output logic                     o_valid,
    output logic [1:0]               o_column_index,
    output logic [1:0]               o_row_index,
    output logic signed [31:0]       o_view_entry,
    output logic signed [31:0]       o_inverse_entry,
    output logic                     o_last_entry
);
    eyvm_pkg::t_item in_item, q_item;
    logic q_full, q_avail, q_pop;

    always_comb begin
        in_item.px = i_pos_x;
        in_item.py = i_pos_y;
        in_item.pz = i_pos_z;
        in_item.pitch = i_pitch_angle;
        in_item.yaw = i_yaw_angle;
        in_item.roll = i_roll_angle;
    end

    assign busy = q_full;

    eyvm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(start && !q_full), .i_item(in_item),
        .i_pop(q_pop), .o_full(q_full), .o_avail(q_avail), .o_item(q_item)
    );

    eyvm_back #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_avail(q_avail), .i_item(q_item), .o_pop(q_pop),
        .o_valid(o_valid), .o_column_index(o_column_index),
        .o_row_index(o_row_index), .o_view_entry(o_view_entry),
        .o_inverse_entry(o_inverse_entry), .o_last_entry(o_last_entry)
    );
endmodule
`default_nettype wire

// ===== rtl/eyvm_front.sv =====
`default_nettype none
module eyvm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire eyvm_pkg::t_item i_item,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_avail,
    output eyvm_pkg::t_item     o_item
);
    eyvm_pkg::t_item r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_q[r_wp] <= i_item;
    end

    assign o_full = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item = r_q[r_rp];
endmodule
`default_nettype wire

// ===== rtl/eyvm_back.sv =====
`default_nettype none
module eyvm_back #(
    parameter int TRIG_ITERATIONS = eyvm_pkg::TrigIterDefault
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_avail,
    input  wire eyvm_pkg::t_item i_item,
    output logic                 o_pop,
    output logic                 o_valid,
    output logic [1:0]           o_column_index,
    output logic [1:0]           o_row_index,
    output logic signed [31:0]   o_view_entry,
    output logic signed [31:0]   o_inverse_entry,
    output logic                 o_last_entry
);
    localparam int NIter = (TRIG_ITERATIONS > eyvm_pkg::AtanCount) ?
        eyvm_pkg::AtanCount : TRIG_ITERATIONS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TRIG = 5'b00010,
        S_MUL  = 5'b00100,
        S_DOT  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_st;
    eyvm_pkg::t_item r_it;
    logic [1:0] r_ang;
    logic [4:0] r_i;
    logic signed [33:0] r_x, r_y, r_z;
    logic r_neg;
    logic signed [31:0] r_s [3];
    logic signed [31:0] r_c [3];
    logic signed [31:0] r_t [12];
    logic [4:0] r_step;
    logic signed [31:0] r_b [9];
    logic signed [49:0] r_acc;
    logic signed [31:0] r_tr [3];
    logic [3:0] r_k;

    logic signed [15:0] ang;
    logic signed [33:0] z0, xs, ys, atn;
    logic signed [33:0] xf, yf;
    logic signed [31:0] ma, mb, mq;
    logic signed [63:0] prod;

    always_comb begin
        unique case (r_ang)
            2'd0: ang = r_it.yaw;
            2'd1: ang = r_it.pitch;
            default: ang = r_it.roll;
        endcase
        z0 = {{1{ang[15]}}, ang, 17'd0};
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        atn = eyvm_pkg::atan_q30(r_i);
        xf = r_neg ? -r_x : r_x;
        yf = r_neg ? -r_y : r_y;
    end

    function automatic logic signed [31:0] clampq(input logic signed [33:0] v);
        if (v > eyvm_pkg::Q30One) return 32'sh4000_0000;
        if (v < -eyvm_pkg::Q30One) return -32'sh4000_0000;
        return v[31:0];
    endfunction

    // Product schedule: 0 c1c3,1 s1s2,2 c2s3,3 c1s2,4 s1c3,5 c1s3,6 c2c3,
    // 7 s1s3,8 s1c2,9 c1c2, then 10 (s1s2)s3,11 (c1s2)s3,12 (s1s2)c3,13 (c1s2)c3.
    always_comb begin
        ma = '0; mb = '0;
        unique case (r_step)
            5'd0: begin ma = r_c[0]; mb = r_c[2]; end
            5'd1: begin ma = r_s[0]; mb = r_s[1]; end
            5'd2: begin ma = r_c[1]; mb = r_s[2]; end
            5'd3: begin ma = r_c[0]; mb = r_s[1]; end
            5'd4: begin ma = r_s[0]; mb = r_c[2]; end
            5'd5: begin ma = r_c[0]; mb = r_s[2]; end
            5'd6: begin ma = r_c[1]; mb = r_c[2]; end
            5'd7: begin ma = r_s[0]; mb = r_s[2]; end
            5'd8: begin ma = r_s[0]; mb = r_c[1]; end
            5'd9: begin ma = r_c[0]; mb = r_c[1]; end
            5'd10: begin ma = r_t[1]; mb = r_s[2]; end
            5'd11: begin ma = r_t[3]; mb = r_s[2]; end
            5'd12: begin ma = r_t[1]; mb = r_c[2]; end
            5'd13: begin ma = r_t[3]; mb = r_c[2]; end
            default: begin ma = '0; mb = '0; end
        endcase
        prod = ma * mb + 64'sd536870912;
        mq = prod[61:30];
    end

    logic [1:0] dv, dp;
    logic signed [31:0] dbv, dpv;
    logic signed [63:0] dprod;
    logic signed [49:0] dsum, trn;
    logic signed [33:0] tfin;
    always_comb begin
        dv = r_step[3:2] == 2'd3 ? 2'd0 : r_step[3:2];
        dp = r_step[1:0] == 2'd3 ? 2'd0 : r_step[1:0];
        dbv = r_b[dv * 3 + dp];
        unique case (dp)
            2'd0: dpv = r_it.px;
            2'd1: dpv = r_it.py;
            default: dpv = r_it.pz;
        endcase
        dprod = dbv * dpv;
        dsum = r_acc + 50'(dprod >>> 14);
        trn = (dsum + 50'sd32768) >>> 16;
        tfin = -34'(trn);
    end

    logic signed [31:0] sat_t;
    always_comb begin
        if (tfin > 34'sd2147483647) sat_t = 32'sh7FFF_FFFF;
        else if (tfin < -34'sd2147483648) sat_t = 32'sh8000_0000;
        else sat_t = tfin[31:0];
    end

    logic [1:0] col, row;
    logic signed [31:0] bq_v, bq_i, vv, iv;
    always_comb begin
        col = r_k[3:2];
        row = r_k[1:0];
        bq_v = r_b[(row == 2'd3 ? 2'd0 : row) * 3 + (col == 2'd3 ? 2'd0 : col)];
        bq_i = r_b[(col == 2'd3 ? 2'd0 : col) * 3 + (row == 2'd3 ? 2'd0 : row)];
        if (col != 2'd3 && row != 2'd3) begin
            vv = 32'((34'(bq_v) + 34'sd8192) >>> 14);
            iv = 32'((34'(bq_i) + 34'sd8192) >>> 14);
        end else if (col != 2'd3) begin
            vv = '0; iv = '0;
        end else if (row != 2'd3) begin
            vv = r_tr[row];
            unique case (row)
                2'd0: iv = r_it.px;
                2'd1: iv = r_it.py;
                default: iv = r_it.pz;
            endcase
        end else begin
            vv = eyvm_pkg::OneQ16; iv = eyvm_pkg::OneQ16;
        end
    end

    assign o_pop = (r_st == S_IDLE) && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            o_last_entry <= 1'b0;
            r_st <= S_IDLE;
        end else begin
            o_valid <= (r_st == S_OUT);
            o_last_entry <= (r_st == S_OUT) && (r_k == 4'd15);
            unique case (r_st)
                S_IDLE: if (i_avail) begin
                    r_it <= i_item;
                    r_ang <= 2'd0;
                    r_i <= 5'd31;
                    r_st <= S_TRIG;
                end
                S_TRIG: begin
                    if (r_i == 5'd31) begin
                        r_x <= eyvm_pkg::GainInv;
                        r_y <= '0;
                        r_i <= '0;
                        if (z0 > eyvm_pkg::Q30HalfPi) begin
                            r_z <= z0 - eyvm_pkg::Q30Pi; r_neg <= 1'b1;
                        end else if (z0 < -eyvm_pkg::Q30HalfPi) begin
                            r_z <= z0 + eyvm_pkg::Q30Pi; r_neg <= 1'b1;
                        end else begin
                            r_z <= z0; r_neg <= 1'b0;
                        end
                    end else if (r_i == 5'(NIter)) begin
                        r_s[r_ang] <= clampq(yf);
                        r_c[r_ang] <= clampq(xf);
                        r_i <= 5'd31;
                        if (r_ang == 2'd2) begin
                            r_step <= '0;
                            r_st <= S_MUL;
                        end
                        r_ang <= r_ang + 2'd1;
                    end else begin
                        if (!r_z[33]) begin
                            r_x <= r_x - ys; r_y <= r_y + xs; r_z <= r_z - atn;
                        end else begin
                            r_x <= r_x + ys; r_y <= r_y - xs; r_z <= r_z + atn;
                        end
                        r_i <= r_i + 5'd1;
                    end
                end
                S_MUL: begin
                    if (r_step < 5'd10) r_t[r_step[3:0]] <= mq;
                    else if (r_step == 5'd10) r_t[10] <= mq;
                    else if (r_step == 5'd11) r_t[11] <= mq;
                    else if (r_step == 5'd12) r_t[1] <= mq;
                    else if (r_step == 5'd13) r_t[3] <= mq;
                    if (r_step == 5'd14) begin
                        r_b[0] <= r_t[0] + r_t[10];
                        r_b[1] <= r_t[2];
                        r_b[2] <= r_t[11] - r_t[4];
                        r_b[3] <= r_t[1] - r_t[5];
                        r_b[4] <= r_t[6];
                        r_b[5] <= r_t[3] + r_t[7];
                        r_b[6] <= r_t[8];
                        r_b[7] <= -r_s[1];
                        r_b[8] <= r_t[9];
                        r_step <= '0;
                        r_acc <= '0;
                        r_st <= S_DOT;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                S_DOT: begin
                    if (r_step[1:0] == 2'd2) begin
                        r_tr[r_step[3:2]] <= sat_t;
                        r_acc <= '0;
                        if (r_step[3:2] == 2'd2) begin
                            r_k <= '0;
                            r_st <= S_OUT;
                        end
                        r_step <= r_step + 5'd2;
                    end else begin
                        r_acc <= dsum;
                        r_step <= r_step + 5'd1;
                    end
                end
                S_OUT: begin
                    o_column_index <= col;
                    o_row_index <= row;
                    o_view_entry <= vv;
                    o_inverse_entry <= iv;
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd15) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/eyvm_checker.sv =====
`default_nettype none
module eyvm_checker #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [15:0] i_pitch_angle,
    input  wire logic signed [15:0] i_yaw_angle,
    input  wire logic signed [15:0] i_roll_angle,
    input  wire logic               o_valid,
    input  wire logic [1:0]         o_column_index,
    input  wire logic [1:0]         o_row_index,
    input  wire logic signed [31:0] o_view_entry,
    input  wire logic signed [31:0] o_inverse_entry,
    input  wire logic               o_last_entry,
    output int                      fail_count,
    output int                      pending_entries
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]         col;
        logic [1:0]         row;
        logic signed [31:0] view;
        logic signed [31:0] inv;
        logic               last;
    } t_entry;

    t_entry entry_q[$];

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic sin_cos(input logic signed [15:0] ang, output longint s, output longint c);
        longint z, x, y, xs, ys;
        bit flip;
        int n;
        z = longint'(ang) * 131072;
        x = eyvm_pkg::GainInv;
        y = 0;
        flip = 0;
        n = TRIG_ITERATIONS > eyvm_pkg::AtanCount ? eyvm_pkg::AtanCount : TRIG_ITERATIONS;
        if (z > eyvm_pkg::Q30HalfPi) begin
            z -= eyvm_pkg::Q30Pi;
            flip = 1;
        end else if (z < -eyvm_pkg::Q30HalfPi) begin
            z += eyvm_pkg::Q30Pi;
            flip = 1;
        end
        for (int i = 0; i < n; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(eyvm_pkg::atan_q30(5'(i)));
            end else begin
                x += ys; y -= xs; z += longint'(eyvm_pkg::atan_q30(5'(i)));
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clampl(x, -eyvm_pkg::Q30One, eyvm_pkg::Q30One);
        s = clampl(y, -eyvm_pkg::Q30One, eyvm_pkg::Q30One);
    endtask

    function automatic longint qmul(longint a, longint b);
        return asr(a * b + (longint'(1) << 29), 30);
    endfunction

    task automatic predict_matrices(input eyvm_pkg::t_item it);
        longint p[3], b[3][3], tr[3];
        longint s1, c1, s2, c2, s3, c3, sum, t, ve, ie;
        t_entry e;
        p[0] = it.px; p[1] = it.py; p[2] = it.pz;
        sin_cos(it.yaw, s1, c1);
        sin_cos(it.pitch, s2, c2);
        sin_cos(it.roll, s3, c3);
        b[0][0] = qmul(c1, c3) + qmul(qmul(s1, s2), s3);
        b[0][1] = qmul(c2, s3);
        b[0][2] = qmul(qmul(c1, s2), s3) - qmul(s1, c3);
        b[1][0] = qmul(qmul(s1, s2), c3) - qmul(c1, s3);
        b[1][1] = qmul(c2, c3);
        b[1][2] = qmul(qmul(c1, s2), c3) + qmul(s1, s3);
        b[2][0] = qmul(s1, c2);
        b[2][1] = -s2;
        b[2][2] = qmul(c1, c2);
        for (int k = 0; k < 3; k++) begin
            sum = 0;
            for (int i = 0; i < 3; i++) sum += asr(b[k][i] * p[i], 14);
            t = asr(sum + 32768, 16);
            tr[k] = clampl(-t, -64'sd2147483648, 64'sd2147483647);
        end
        for (int k = 0; k < 16; k++) begin
            int col, row;
            col = k >> 2;
            row = k & 3;
            if (col < 3 && row < 3) begin
                ve = asr(b[row][col] + 8192, 14);
                ie = asr(b[col][row] + 8192, 14);
            end else if (col < 3) begin
                ve = 0; ie = 0;
            end else if (row < 3) begin
                ve = tr[row]; ie = p[row];
            end else begin
                ve = eyvm_pkg::OneQ16; ie = eyvm_pkg::OneQ16;
            end
            e.col = 2'(col);
            e.row = 2'(row);
            e.view = 32'(ve);
            e.inv = 32'(ie);
            e.last = (k == 15);
            entry_q.push_back(e);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_entry e;
        if (i_rst_n && o_valid) begin
            if (entry_q.size() == 0) begin
                report_mismatch("unexpected entry", o_view_entry, 0);
            end else begin
                e = entry_q.pop_front();
                if (o_column_index !== e.col) report_mismatch("column", o_column_index, e.col);
                if (o_row_index !== e.row) report_mismatch("row", o_row_index, e.row);
                if (o_view_entry !== e.view) report_mismatch("view", o_view_entry, e.view);
                if (o_inverse_entry !== e.inv)
                    report_mismatch("inverse", o_inverse_entry, e.inv);
                if (o_last_entry !== e.last) report_mismatch("last", o_last_entry, e.last);
            end
        end
        if (i_rst_n && start && !busy)
            predict_matrices('{i_pos_x, i_pos_y, i_pos_z, i_pitch_angle, i_yaw_angle, i_roll_angle});
        pending_entries = entry_q.size();
    end
endmodule
`default_nettype wire

// ===== tb/sv/tb_euler_yxz_view_matrix.sv =====
`default_nettype none
module tb_euler_yxz_view_matrix;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Iters = 16;
    localparam int Latency = 3 * (Iters + 2) + 60;

    logic i_clk = 0, i_rst_n = 0, start = 0;
    logic busy, o_valid, o_last_entry;
    logic signed [31:0] i_pos_x = 0, i_pos_y = 0, i_pos_z = 0;
    logic signed [15:0] i_pitch_angle = 0, i_yaw_angle = 0, i_roll_angle = 0;
    logic [1:0] o_column_index, o_row_index;
    logic signed [31:0] o_view_entry, o_inverse_entry;
    int fail_count, pending_entries;

    euler_yxz_view_matrix #(.TRIG_ITERATIONS(Iters)) dut (.*);
    eyvm_checker #(.TRIG_ITERATIONS(Iters)) checker_i (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return 32'($signed($urandom_range(0, 2 * 65536 * 16)) - 65536 * 16);
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 16'($signed($urandom_range(0, 2 * 12868)) - 12868);
            1: return 16'($signed($urandom_range(0, 2 * 25736)) - 25736);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_camera(input eyvm_pkg::t_item it);
        int idle;
        idle = $urandom_range(0, 4);
        if (idle != 0) begin
            start <= 0;
            repeat (idle) @(negedge i_clk);
        end
        i_pos_x <= it.px; i_pos_y <= it.py; i_pos_z <= it.pz;
        i_pitch_angle <= it.pitch; i_yaw_angle <= it.yaw; i_roll_angle <= it.roll;
        start <= 1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    initial begin
        eyvm_pkg::t_item it;
        logic signed [15:0] angles[10];
        angles = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh3244, 16'shCDBC,
                   16'sh3243, 16'sh6488, 16'sh9B78, 16'sh1921, 16'shFFFF};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        for (int k = 0; k < 10; k++)
            send_camera('{32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000,
                          angles[k], angles[(k + 3) % 10], angles[(k + 7) % 10]});
        send_camera('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh1000, 16'sh1000, 0});
        send_camera('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'shE000, 0, 16'sh2000});
        send_camera('{32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 16'h7FFF});
        send_camera('{0, 0, 0, 0, 0, 0});
        for (int n = 0; n < 400; n++) begin
            it = '{rand_pos(), rand_pos(), rand_pos(), rand_angle(), rand_angle(), rand_angle()};
            send_camera(it);
        end
        start <= 0;
        do @(posedge i_clk); while (pending_entries != 0);
        repeat (Latency) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(2_000_000 * 20);
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
